// ===== rtl/core/jsv_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON syntax validator package
// Shared types, constants and character-class helpers.
// ----------------------------------------------------------------------------
package jsv_pkg;

  localparam int MaxDepth = 64;
  localparam int LevelW = $clog2(MaxDepth + 1);
  localparam int IdxW = (MaxDepth > 1) ? $clog2(MaxDepth) : 1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_doc;
  } in_beat_t;

  typedef struct packed {
    logic        accepted;
    logic [2:0]  error_kind;
    logic [31:0] error_offset;
  } out_beat_t;

  typedef enum logic [3:0] {
    M_TOP, M_VALUE, M_KEY, M_COLON, M_AFTER, M_STR_VAL, M_STR_KEY,
    M_ESC_VAL, M_ESC_KEY, M_HEX_VAL, M_HEX_KEY, M_LIT, M_NUM, M_TRAIL
  } mode_t;

  localparam logic [2:0] ErrNone = 3'd0;
  localparam logic [2:0] ErrChar = 3'd1;
  localparam logic [2:0] ErrString = 3'd2;
  localparam logic [2:0] ErrLiteral = 3'd3;
  localparam logic [2:0] ErrNumber = 3'd4;
  localparam logic [2:0] ErrDepth = 3'd5;
  localparam logic [2:0] ErrEnd = 3'd6;
  localparam logic [2:0] ErrTrail = 3'd7;

  // Parser state handed from the stack stage to the step logic.
  typedef struct packed {
    logic              top_obj;
    logic [LevelW-1:0] level;
  } stack_view_t;

  // Stack update request from the step logic.
  typedef struct packed {
    logic    push;
    logic    pop;
    logic    kind;
  } stack_op_t;

  function automatic logic is_ws(input logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0D;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  // Expected literal byte after the first letter.
  function automatic logic [7:0] lit_char(input logic [1:0] k, input logic [2:0] i);
    logic [7:0] r;
    r = 8'h00;
    case (k)
      2'd0: r = (i == 3'd0) ? "u" : (i == 3'd1 || i == 3'd2) ? "l" : 8'h00;
      2'd1: r = (i == 3'd0) ? "r" : (i == 3'd1) ? "u" : (i == 3'd2) ? "e" : 8'h00;
      2'd2: r = (i == 3'd0) ? "a" : (i == 3'd1) ? "l" : (i == 3'd2) ? "s" :
                (i == 3'd3) ? "e" : 8'h00;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // Next number phase; 8 means the byte does not extend the number.
  function automatic logic [3:0] num_next(input logic [2:0] ph, input logic [7:0] c);
    logic d;
    logic e;
    d = is_digit(c);
    e = (c == "e") || (c == "E");
    case (ph)
      3'd0: num_next = (c == "0") ? 4'd1 : d ? 4'd2 : 4'd8;
      3'd1: num_next = (c == ".") ? 4'd3 : e ? 4'd5 : 4'd8;
      3'd2: num_next = d ? 4'd2 : (c == ".") ? 4'd3 : e ? 4'd5 : 4'd8;
      3'd3: num_next = d ? 4'd4 : 4'd8;
      3'd4: num_next = d ? 4'd4 : e ? 4'd5 : 4'd8;
      3'd5: num_next = (c == "+" || c == "-") ? 4'd6 : d ? 4'd7 : 4'd8;
      3'd6: num_next = d ? 4'd7 : 4'd8;
      default: num_next = d ? 4'd7 : 4'd8;
    endcase
  endfunction

endpackage

// ===== rtl/core/jsv_stack.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON validator kind stack
// Holds the open container kinds (1 = object) and the nesting level.
// ----------------------------------------------------------------------------
module jsv_stack (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 doc_end,
  input  jsv_pkg::stack_op_t   op,
  output jsv_pkg::stack_view_t view
);

  logic                         kinds [jsv_pkg::MaxDepth];
  logic [jsv_pkg::LevelW-1:0]   level;
  logic [jsv_pkg::LevelW-1:0]   below_idx;
  logic                         top_obj;

  // Kind memory needs no reset; only entries below the level are read.
  always_ff @(posedge clk) begin
    if (op.push) begin
      kinds[level[jsv_pkg::IdxW-1:0]] <= op.kind;
    end
  end

  // Entry under the current top, which becomes the top after a pop.
  assign below_idx = level - jsv_pkg::LevelW'(2);

  // Nesting level and a registered copy of the top kind, cleared at reset
  // and at the end of each document. A push takes the new kind directly;
  // a pop reads the entry below the old top.
  always_ff @(posedge clk) begin
    if (rst || doc_end) begin
      level <= '0;
      top_obj <= 1'b0;
    end else if (op.push) begin
      level <= level + 1'b1;
      top_obj <= op.kind;
    end else if (op.pop) begin
      level <= level - 1'b1;
      top_obj <= (level > jsv_pkg::LevelW'(1)) && kinds[below_idx[jsv_pkg::IdxW-1:0]];
    end
  end

  assign view.level = level;
  assign view.top_obj = top_obj;

endmodule

// ===== rtl/core/json_syntax_validator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Streaming JSON syntax validator
// Checks one document byte per beat and reports accept or the first error.
// ----------------------------------------------------------------------------
// The result beat is registered: it appears in the cycle after the last byte is accepted.
// Throughput: one byte per cycle while in_ready is high; the parser state is registered per byte.
// The output register is decoupled: a new byte is taken while a result waits,
// unless the result register is full and not being drained.
// Reset (rst, synchronous): depth_limit returns to 64, parser state clears.
module json_syntax_validator (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  jsv_pkg::in_beat_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output jsv_pkg::out_beat_t  out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [6:0]          cfg_data
);

  jsv_pkg::mode_t       mode, mode_next;
  logic                 first, first_next;
  logic [2:0]           sub_count, sub_count_next;
  logic [1:0]           lit_kind, lit_kind_next;
  logic [2:0]           num_phase, num_phase_next;
  logic [2:0]           err, err_next;
  logic [31:0]          err_pos, err_pos_next;
  logic [31:0]          pos, pos_inc;
  logic [6:0]           depth_limit;
  jsv_pkg::stack_view_t view;
  jsv_pkg::stack_op_t   op;
  logic                 fire, doc_end;
  logic [7:0]           c;
  logic [3:0]           nx;
  logic [jsv_pkg::LevelW:0] lim;

  assign cfg_ready = 1'b1;
  assign in_ready = !out_valid || out_ready;
  assign fire = in_valid && in_ready;
  assign doc_end = fire && in_data.end_of_doc;
  assign c = in_data.data_byte;
  assign pos_inc = (pos == 32'hFFFF_FFFF) ? pos : pos + 32'd1;
  assign lim = ({1'b0, depth_limit} < (jsv_pkg::LevelW + 1)'(jsv_pkg::MaxDepth))
             ? (jsv_pkg::LevelW + 1)'(depth_limit) : (jsv_pkg::LevelW + 1)'(jsv_pkg::MaxDepth);

  jsv_stack u_stack (
    .clk     (clk),
    .rst     (rst),
    .doc_end (doc_end),
    .op      (op),
    .view    (view)
  );

  // One parser step for the byte at the input.
  always_comb begin
    logic key;
    logic do_after;
    logic do_open;
    logic open_obj;
    mode_next = mode;
    first_next = first;
    sub_count_next = sub_count;
    lit_kind_next = lit_kind;
    num_phase_next = num_phase;
    err_next = err;
    err_pos_next = err_pos;
    op = '0;
    key = 1'b0;
    do_after = 1'b0;
    do_open = 1'b0;
    open_obj = 1'b0;
    nx = jsv_pkg::num_next(num_phase, c);
    if (err == jsv_pkg::ErrNone) begin
      case (mode)
        jsv_pkg::M_TOP: begin
          if (c == "[" || c == "{") begin
            do_open = 1'b1;
            open_obj = (c == "{");
          end else if (!jsv_pkg::is_ws(c)) begin
            err_next = jsv_pkg::ErrChar;
          end
        end
        jsv_pkg::M_VALUE: begin
          if (!jsv_pkg::is_ws(c)) begin
            if (c == "]" && first && view.level != '0 && !view.top_obj) begin
              op.pop = 1'b1;
              mode_next = (view.level == 1) ? jsv_pkg::M_TRAIL : jsv_pkg::M_AFTER;
            end else begin
              first_next = 1'b0;
              if (c == "\"") begin
                mode_next = jsv_pkg::M_STR_VAL;
              end else if (c == "[" || c == "{") begin
                do_open = 1'b1;
                open_obj = (c == "{");
              end else if (c == "n" || c == "t" || c == "f") begin
                lit_kind_next = (c == "n") ? 2'd0 : (c == "t") ? 2'd1 : 2'd2;
                sub_count_next = '0;
                mode_next = jsv_pkg::M_LIT;
              end else if (c == "-" || jsv_pkg::is_digit(c)) begin
                num_phase_next = (c == "-") ? 3'd0 : (c == "0") ? 3'd1 : 3'd2;
                mode_next = jsv_pkg::M_NUM;
              end else begin
                err_next = jsv_pkg::ErrChar;
              end
            end
          end
        end
        jsv_pkg::M_KEY: begin
          if (c == "\"") begin
            first_next = 1'b0;
            mode_next = jsv_pkg::M_STR_KEY;
          end else if (c == "}" && first) begin
            op.pop = 1'b1;
            mode_next = (view.level == 1) ? jsv_pkg::M_TRAIL : jsv_pkg::M_AFTER;
          end else if (!jsv_pkg::is_ws(c)) begin
            err_next = jsv_pkg::ErrChar;
          end
        end
        jsv_pkg::M_COLON: begin
          if (c == ":") mode_next = jsv_pkg::M_VALUE;
          else if (!jsv_pkg::is_ws(c)) err_next = jsv_pkg::ErrChar;
        end
        jsv_pkg::M_AFTER: do_after = 1'b1;
        jsv_pkg::M_STR_KEY, jsv_pkg::M_STR_VAL: begin
          key = (mode == jsv_pkg::M_STR_KEY);
          if (c == "\"") mode_next = key ? jsv_pkg::M_COLON : jsv_pkg::M_AFTER;
          else if (c == "\\") mode_next = key ? jsv_pkg::M_ESC_KEY : jsv_pkg::M_ESC_VAL;
          else if (c < 8'd32 || c == 8'd127) err_next = jsv_pkg::ErrString;
        end
        jsv_pkg::M_ESC_KEY, jsv_pkg::M_ESC_VAL: begin
          key = (mode == jsv_pkg::M_ESC_KEY);
          if (c == "u") begin
            sub_count_next = '0;
            mode_next = key ? jsv_pkg::M_HEX_KEY : jsv_pkg::M_HEX_VAL;
          end else if (c == "\"" || c == "\\" || c == "/" || c == "b" || c == "f" ||
                       c == "n" || c == "r" || c == "t") begin
            mode_next = key ? jsv_pkg::M_STR_KEY : jsv_pkg::M_STR_VAL;
          end else begin
            err_next = jsv_pkg::ErrString;
          end
        end
        jsv_pkg::M_HEX_KEY, jsv_pkg::M_HEX_VAL: begin
          key = (mode == jsv_pkg::M_HEX_KEY);
          if (!jsv_pkg::is_hex(c)) begin
            err_next = jsv_pkg::ErrString;
          end else if (sub_count == 3'd3) begin
            sub_count_next = '0;
            mode_next = key ? jsv_pkg::M_STR_KEY : jsv_pkg::M_STR_VAL;
          end else begin
            sub_count_next = sub_count + 3'd1;
          end
        end
        jsv_pkg::M_LIT: begin
          if (jsv_pkg::lit_char(lit_kind, sub_count) != c || c == 8'h00) begin
            err_next = jsv_pkg::ErrLiteral;
          end else if (sub_count == ((lit_kind == 2'd2) ? 3'd3 : 3'd2)) begin
            sub_count_next = '0;
            mode_next = jsv_pkg::M_AFTER;
          end else begin
            sub_count_next = sub_count + 3'd1;
          end
        end
        jsv_pkg::M_NUM: begin
          if (nx != 4'd8) begin
            num_phase_next = nx[2:0];
          end else if (num_phase == 3'd1 || num_phase == 3'd2 || num_phase == 3'd4 ||
                       num_phase == 3'd7) begin
            num_phase_next = '0;
            mode_next = jsv_pkg::M_AFTER;
            do_after = 1'b1;
          end else begin
            err_next = jsv_pkg::ErrNumber;
          end
        end
        jsv_pkg::M_TRAIL: begin
          if (!jsv_pkg::is_ws(c)) err_next = jsv_pkg::ErrTrail;
        end
        default: err_next = jsv_pkg::ErrChar;
      endcase
      // Byte following a complete value.
      if (do_after && !jsv_pkg::is_ws(c)) begin
        if (c == ",") begin
          first_next = 1'b0;
          mode_next = view.top_obj ? jsv_pkg::M_KEY : jsv_pkg::M_VALUE;
        end else if ((c == "]" && !view.top_obj) || (c == "}" && view.top_obj)) begin
          op.pop = 1'b1;
          mode_next = (view.level == 1) ? jsv_pkg::M_TRAIL : jsv_pkg::M_AFTER;
        end else begin
          err_next = jsv_pkg::ErrChar;
        end
      end
      // Container open with depth check.
      if (do_open) begin
        if ({1'b0, view.level} >= lim) begin
          err_next = jsv_pkg::ErrDepth;
        end else begin
          op.push = 1'b1;
          op.kind = open_obj;
          first_next = 1'b1;
          mode_next = open_obj ? jsv_pkg::M_KEY : jsv_pkg::M_VALUE;
        end
      end
      if (err_next != jsv_pkg::ErrNone) err_pos_next = pos;
    end
    if (!fire) begin
      op = '0;
    end
  end

  // Parser state and configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      depth_limit <= 7'd64;
    end else if (cfg_valid && cfg_ready) begin
      depth_limit <= cfg_data;
    end
    if (rst || doc_end) begin
      mode <= jsv_pkg::M_TOP;
      first <= 1'b1;
      sub_count <= '0;
      lit_kind <= '0;
      num_phase <= '0;
      err <= jsv_pkg::ErrNone;
      err_pos <= '0;
      pos <= '0;
    end else if (fire) begin
      mode <= mode_next;
      first <= first_next;
      sub_count <= sub_count_next;
      lit_kind <= lit_kind_next;
      num_phase <= num_phase_next;
      err <= err_next;
      err_pos <= err_pos_next;
      pos <= pos_inc;
    end
  end

  // Result register, loaded on the byte with the end mark.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (doc_end) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (doc_end) begin
      if (err_next == jsv_pkg::ErrNone && mode_next != jsv_pkg::M_TRAIL) begin
        out_data.accepted <= 1'b0;
        out_data.error_kind <= jsv_pkg::ErrEnd;
        out_data.error_offset <= pos_inc;
      end else begin
        out_data.accepted <= (err_next == jsv_pkg::ErrNone);
        out_data.error_kind <= err_next;
        out_data.error_offset <= (err_next == jsv_pkg::ErrNone) ? 32'd0 : err_pos_next;
      end
    end
  end

  // A result can only appear right after an end-marked byte.
  a_out_after_end: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(doc_end)) else $error("result without end mark");
  // Accepted results carry no error kind.
  a_accept_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.accepted |-> out_data.error_kind == jsv_pkg::ErrNone)
    else $error("accepted with error kind");
  // The level never exceeds the build depth.
  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    view.level <= jsv_pkg::LevelW'(jsv_pkg::MaxDepth)) else $error("stack overflow");

endmodule

// ===== tb/sv/json_verdict_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON validator verdict checker
// Watches the byte, verdict and depth limit channels of the validator, keeps
// its own copy of the parser state and checks every verdict beat in order.
// ----------------------------------------------------------------------------
module json_verdict_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  jsv_pkg::in_beat_t  in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  jsv_pkg::out_beat_t out_data,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [6:0]         cfg_data,
  output int                 errors,
  output int                 pending
);

  // Shadow parser state.
  jsv_pkg::mode_t pmode;
  logic [63:0]    kinds;
  int             lvl;
  logic           first;
  int             sub;
  int             lit;
  int             nph;
  logic [2:0]     ecode;
  logic [31:0]    epos;
  logic [31:0]    bpos;
  logic [6:0]     limit_reg;

  jsv_pkg::out_beat_t verdicts_due[$];

  assign pending = verdicts_due.size();

  function automatic logic blank(input logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0D;
  endfunction

  function automatic logic dec(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic hexd(input logic [7:0] c);
    return dec(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  // Letter expected at position i of the tail of null, true or false.
  function automatic logic [7:0] tail_char(input int k, input int i);
    string t;
    if (k == 0) t = "ull";
    else if (k == 1) t = "rue";
    else t = "alse";
    return (i < t.len()) ? t[i] : 8'h00;
  endfunction

  function automatic int tail_len(input int k);
    return (k == 2) ? 4 : 3;
  endfunction

  // Number grammar step; 8 means the byte cannot extend the number.
  function automatic int num_advance(input int ph, input logic [7:0] c);
    logic d;
    logic e;
    d = dec(c);
    e = (c == "e") || (c == "E");
    case (ph)
      0: return (c == "0") ? 1 : d ? 2 : 8;
      1: return (c == ".") ? 3 : e ? 5 : 8;
      2: return d ? 2 : (c == ".") ? 3 : e ? 5 : 8;
      3: return d ? 4 : 8;
      4: return d ? 4 : e ? 5 : 8;
      5: return (c == "+" || c == "-") ? 6 : d ? 7 : 8;
      default: return d ? 7 : 8;
    endcase
  endfunction

  function automatic void flag(input logic [2:0] k);
    if (ecode == jsv_pkg::ErrNone) begin
      ecode = k;
      epos = bpos;
    end
  endfunction

  function automatic logic in_object();
    return (lvl == 0) ? 1'b0 : kinds[lvl-1];
  endfunction

  function automatic void open_level(input logic obj);
    int cap;
    cap = (limit_reg < 64) ? limit_reg : 64;
    if (lvl >= cap) begin
      flag(jsv_pkg::ErrDepth);
      return;
    end
    kinds[lvl] = obj;
    lvl++;
    first = 1'b1;
    pmode = obj ? jsv_pkg::M_KEY : jsv_pkg::M_VALUE;
  endfunction

  function automatic void close_level();
    lvl--;
    pmode = (lvl == 0) ? jsv_pkg::M_TRAIL : jsv_pkg::M_AFTER;
  endfunction

  function automatic void value_start(input logic [7:0] c);
    if (c == "]" && first && lvl > 0 && !in_object()) begin
      close_level();
      return;
    end
    first = 1'b0;
    if (c == "\"") pmode = jsv_pkg::M_STR_VAL;
    else if (c == "[") open_level(1'b0);
    else if (c == "{") open_level(1'b1);
    else if (c == "n" || c == "t" || c == "f") begin
      lit = (c == "n") ? 0 : (c == "t") ? 1 : 2;
      sub = 0;
      pmode = jsv_pkg::M_LIT;
    end else if (c == "-" || dec(c)) begin
      nph = (c == "-") ? 0 : (c == "0") ? 1 : 2;
      pmode = jsv_pkg::M_NUM;
    end else flag(jsv_pkg::ErrChar);
  endfunction

  function automatic void value_done(input logic [7:0] c);
    if (blank(c)) return;
    if (c == ",") begin
      first = 1'b0;
      pmode = in_object() ? jsv_pkg::M_KEY : jsv_pkg::M_VALUE;
    end else if ((c == "]" && !in_object()) || (c == "}" && in_object())) begin
      close_level();
    end else flag(jsv_pkg::ErrChar);
  endfunction

  function automatic void parse_byte(input logic [7:0] c);
    logic key;
    int nx;
    key = (pmode == jsv_pkg::M_STR_KEY || pmode == jsv_pkg::M_ESC_KEY ||
           pmode == jsv_pkg::M_HEX_KEY);
    case (pmode)
      jsv_pkg::M_TOP: begin
        if (c == "[") open_level(1'b0);
        else if (c == "{") open_level(1'b1);
        else if (!blank(c)) flag(jsv_pkg::ErrChar);
      end
      jsv_pkg::M_VALUE: if (!blank(c)) value_start(c);
      jsv_pkg::M_KEY: begin
        if (c == "\"") begin
          first = 1'b0;
          pmode = jsv_pkg::M_STR_KEY;
        end else if (c == "}" && first) close_level();
        else if (!blank(c)) flag(jsv_pkg::ErrChar);
      end
      jsv_pkg::M_COLON: begin
        if (c == ":") pmode = jsv_pkg::M_VALUE;
        else if (!blank(c)) flag(jsv_pkg::ErrChar);
      end
      jsv_pkg::M_AFTER: value_done(c);
      jsv_pkg::M_STR_VAL, jsv_pkg::M_STR_KEY: begin
        if (c == "\"") pmode = key ? jsv_pkg::M_COLON : jsv_pkg::M_AFTER;
        else if (c == "\\") pmode = key ? jsv_pkg::M_ESC_KEY : jsv_pkg::M_ESC_VAL;
        else if (c < 8'd32 || c == 8'd127) flag(jsv_pkg::ErrString);
      end
      jsv_pkg::M_ESC_VAL, jsv_pkg::M_ESC_KEY: begin
        if (c == "u") begin
          sub = 0;
          pmode = key ? jsv_pkg::M_HEX_KEY : jsv_pkg::M_HEX_VAL;
        end else if (c == "\"" || c == "\\" || c == "/" || c == "b" || c == "f" ||
                     c == "n" || c == "r" || c == "t") begin
          pmode = key ? jsv_pkg::M_STR_KEY : jsv_pkg::M_STR_VAL;
        end else flag(jsv_pkg::ErrString);
      end
      jsv_pkg::M_HEX_VAL, jsv_pkg::M_HEX_KEY: begin
        if (!hexd(c)) flag(jsv_pkg::ErrString);
        else begin
          sub++;
          if (sub >= 4) begin
            sub = 0;
            pmode = key ? jsv_pkg::M_STR_KEY : jsv_pkg::M_STR_VAL;
          end
        end
      end
      jsv_pkg::M_LIT: begin
        if (tail_char(lit, sub) != c || sub > 3) flag(jsv_pkg::ErrLiteral);
        else begin
          sub++;
          if (sub >= tail_len(lit)) begin
            sub = 0;
            pmode = jsv_pkg::M_AFTER;
          end
        end
      end
      jsv_pkg::M_NUM: begin
        nx = num_advance(nph, c);
        if (nx < 8) nph = nx;
        else if (nph == 1 || nph == 2 || nph == 4 || nph == 7) begin
          nph = 0;
          pmode = jsv_pkg::M_AFTER;
          value_done(c);
        end else flag(jsv_pkg::ErrNumber);
      end
      jsv_pkg::M_TRAIL: if (!blank(c)) flag(jsv_pkg::ErrTrail);
      default: flag(jsv_pkg::ErrChar);
    endcase
  endfunction

  function automatic void clear_doc();
    pmode = jsv_pkg::M_TOP;
    lvl = 0;
    first = 1'b1;
    sub = 0;
    lit = 0;
    nph = 0;
    ecode = jsv_pkg::ErrNone;
    epos = '0;
    bpos = '0;
  endfunction

  // Advance the shadow parser by one byte beat; queue the verdict on the last.
  function automatic void take_byte(input jsv_pkg::in_beat_t b);
    jsv_pkg::out_beat_t v;
    if (ecode == jsv_pkg::ErrNone) parse_byte(b.data_byte);
    if (bpos != 32'hFFFF_FFFF) bpos++;
    if (!b.end_of_doc) return;
    if (ecode == jsv_pkg::ErrNone && pmode != jsv_pkg::M_TRAIL) begin
      ecode = jsv_pkg::ErrEnd;
      epos = bpos;
    end
    v.accepted = (ecode == jsv_pkg::ErrNone);
    v.error_kind = ecode;
    v.error_offset = (ecode == jsv_pkg::ErrNone) ? 32'd0 : epos;
    verdicts_due.insert(verdicts_due.size(), v);
    clear_doc();
  endfunction

  // Compare each verdict beat against the oldest prediction.
  always @(posedge clk) begin
    jsv_pkg::out_beat_t want;
    int bad;
    bad = 0;
    if (rst) begin
      limit_reg <= 7'd64;
      kinds = '0;
      clear_doc();
      verdicts_due.delete();
      errors <= 0;
    end else begin
      if (cfg_valid && cfg_ready) limit_reg <= cfg_data;
      if (in_valid && in_ready) take_byte(in_data);
      if (out_valid && out_ready) begin
        if (verdicts_due.size() == 0) begin
          $display("%0t: verdict beat expected none, actual %p", $time, out_data);
          bad++;
        end else begin
          want = verdicts_due.pop_front();
          if (want.accepted !== out_data.accepted) begin
            $display("%0t: accepted expected %0d actual %0d", $time,
                     want.accepted, out_data.accepted);
            bad++;
          end
          if (want.error_kind !== out_data.error_kind) begin
            $display("%0t: error_kind expected %0d actual %0d", $time,
                     want.error_kind, out_data.error_kind);
            bad++;
          end
          if (want.error_offset !== out_data.error_offset) begin
            $display("%0t: error_offset expected %0d actual %0d", $time,
                     want.error_offset, out_data.error_offset);
            bad++;
          end
        end
      end
      errors <= errors + bad;
    end
  end

endmodule

// ===== tb/sv/tb_json_syntax_validator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON syntax validator testbench
// Streams directed and randomly generated documents (mostly well formed, some
// mutated or pure noise) under several depth limits, with random gaps on the
// byte side and random stalls on the verdict side.
// ----------------------------------------------------------------------------
module tb_json_syntax_validator;

  localparam int IdleLimit = 3000;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  jsv_pkg::in_beat_t  in_data;
  logic               out_valid;
  logic               out_ready;
  jsv_pkg::out_beat_t out_data;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [6:0]         cfg_data;
  int                 errors;
  int                 pending;

  logic [7:0] doc[$];
  logic       calm;
  int         stall;
  int         idle_cycles;
  int         bytes_sent;

  json_syntax_validator DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  json_verdict_checker checker_i (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Verdict side: a fresh stall of random length after every beat taken, or none while calm.
  always @(posedge clk) begin
    int n;
    if (rst) begin
      out_ready <= 1'b1;
      stall <= 0;
    end else if (out_valid && out_ready) begin
      n = calm ? 0 : $urandom_range(0, 17);
      stall <= n;
      out_ready <= (n == 0);
    end else if (stall != 0) begin
      stall <= stall - 1;
      out_ready <= (stall == 1);
    end
  end

  // Watchdog on cycles with no beat on any channel.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("tb_json_syntax_validator: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Append one byte to the document buffer.
  function automatic void put_byte(input logic [7:0] b);
    doc.insert(doc.size(), b);
  endfunction

  // Drop the byte valid and wait until every verdict has drained.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_limit(input logic [6:0] v);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Send the document buffer; the last byte carries the end mark.
  task automatic send_doc();
    int gap;
    calm = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < doc.size(); i++) begin
      gap = calm ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid <= 1'b1;
      in_data.data_byte <= doc[i];
      in_data.end_of_doc <= (i == doc.size() - 1);
      @(negedge clk);
      while (!in_ready) @(negedge clk);
      @(posedge clk);
      bytes_sent++;
    end
  endtask

  task automatic send_text(input string s);
    doc.delete();
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
    send_doc();
  endtask

  function automatic void put_ws();
    int n;
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
    repeat (n) begin
      case ($urandom_range(0, 3))
        0: put_byte(8'h20);
        1: put_byte(8'h09);
        2: put_byte(8'h0A);
        default: put_byte(8'h0D);
      endcase
    end
  endfunction

  function automatic void put_hex();
    int h;
    h = $urandom_range(0, 21);
    if (h < 10) put_byte(8'(8'h30 + h));
    else if (h < 16) put_byte(8'("a" + h - 10));
    else put_byte(8'("A" + h - 16));
  endfunction

  function automatic void put_string();
    string esc;
    esc = "\"\\/bfnrt";
    put_byte("\"");
    repeat ($urandom_range(0, 5)) begin
      case ($urandom_range(0, 5))
        0: put_byte(8'($urandom_range(128, 255)));
        1: begin
          put_byte("\\");
          put_byte(esc[$urandom_range(0, 7)]);
        end
        2: begin
          put_byte("\\");
          put_byte("u");
          repeat (4) put_hex();
        end
        default: put_byte(8'("a" + $urandom_range(0, 25)));
      endcase
    end
    put_byte("\"");
  endfunction

  function automatic void put_digits(input int n);
    repeat (n) put_byte(8'(8'h30 + $urandom_range(0, 9)));
  endfunction

  function automatic void put_number();
    if ($urandom_range(0, 2) == 0) put_byte("-");
    if ($urandom_range(0, 2) == 0) put_byte("0");
    else begin
      put_byte(8'(8'h30 + $urandom_range(1, 9)));
      put_digits($urandom_range(0, 3));
    end
    if ($urandom_range(0, 2) == 0) begin
      put_byte(".");
      put_digits($urandom_range(1, 3));
    end
    if ($urandom_range(0, 2) == 0) begin
      put_byte($urandom_range(0, 1) ? "e" : "E");
      case ($urandom_range(0, 2))
        0: put_byte("+");
        1: put_byte("-");
        default: ;
      endcase
      put_digits($urandom_range(1, 2));
    end
  endfunction

  function automatic void put_word(input string w);
    for (int i = 0; i < w.len(); i++) put_byte(w[i]);
  endfunction

  function automatic void put_container(input int depth, input logic obj);
    int n;
    n = (depth >= 4) ? 0 : $urandom_range(0, 3);
    put_byte(obj ? "{" : "[");
    put_ws();
    for (int i = 0; i < n; i++) begin
      if (i > 0) begin
        put_byte(",");
        put_ws();
      end
      if (obj) begin
        put_string();
        put_ws();
        put_byte(":");
        put_ws();
      end
      put_value(depth + 1);
      put_ws();
    end
    put_byte(obj ? "}" : "]");
  endfunction

  function automatic void put_value(input int depth);
    case ($urandom_range(0, 7))
      0, 1: put_string();
      2, 3: put_number();
      4: put_word("null");
      5: put_word($urandom_range(0, 1) ? "true" : "false");
      6: put_container(depth, 1'b0);
      default: put_container(depth, 1'b1);
    endcase
  endfunction

  // One random document: mostly well formed, some mutated, a few noise.
  function automatic void make_doc();
    int k;
    int pos;
    doc.delete();
    case ($urandom_range(0, 19))
      0: repeat ($urandom_range(1, 8)) put_byte(8'($urandom_range(0, 255)));
      1: begin
        k = $urandom_range(1, 70);
        repeat (k) put_byte("[");
        repeat (k) put_byte("]");
      end
      default: begin
        put_ws();
        put_container(0, $urandom_range(0, 1));
        put_ws();
      end
    endcase
    if ($urandom_range(0, 3) == 0) begin
      pos = $urandom_range(0, doc.size() - 1);
      case ($urandom_range(0, 3))
        0: doc[pos] = 8'($urandom_range(0, 255));
        1: doc = doc[0:pos];
        2: put_byte(8'("!" + $urandom_range(0, 90)));
        default: doc.insert(pos, 8'($urandom_range(0, 255)));
      endcase
    end
  endfunction

  initial begin
    logic [6:0] lims[$];
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    calm = 1'b0;
    bytes_sent = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed documents at the reset depth limit.
    send_text("[]");
    send_text(" { } \t\r\n");
    send_text("[null,true,false]");
    send_text("{\"a\":-0.5e+10,\"b\":[1E2,0,12.25,-7e3]}");
    send_text("[\"\\\"\\\\\\/\\b\\f\\n\\r\\t\\u09aF\"]");
    send_text("[nul]");
    send_text("[01]");
    send_text("[-]");
    send_text("[1.]");
    send_text("[\"\\x\"]");
    send_text("[\"\\u12g4\"]");
    send_text("[1,]");
    send_text("[}");
    send_text("{\"a\" 1}");
    send_text("{1:2}");
    send_text("[] x");
    send_text("[1");
    send_text("5");
    doc = '{"[", "\"", 8'hFF, 8'h80, "\"", ",", "\"", 8'h7F, "\"", "]"};
    send_doc();
    doc = '{"[", "\"", 8'h01, "\"", "]"};
    send_doc();
    doc.delete();
    repeat (65) put_byte("[");
    repeat (65) put_byte("]");
    send_doc();

    // Limit extremes.
    set_limit(7'd0);
    send_text("[]");
    set_limit(7'd127);
    send_doc();
    set_limit(7'd1);
    send_text("[[]]");
    send_text("{}");

    // Random phases, each under its own limit.
    lims = '{7'd2, 7'd64, 7'd1, 7'd127, 7'd3, 7'd0, 7'd64};
    lims.insert(lims.size(), 7'($urandom_range(1, 63)));
    foreach (lims[p]) begin
      set_limit(lims[p]);
      while (bytes_sent < 150 + 125 * (p + 1)) begin
        make_doc();
        send_doc();
      end
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("tb_json_syntax_validator: done, clean");
    end else begin
      $display("tb_json_syntax_validator: done, errors");
    end
    $finish;
  end

endmodule
